// ----- sv/v2c_pkg.sv -----
package v2c_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_KERNEL = 8;
    localparam int PIXEL_BITS = 16;

    // coefficient store is addressed row*8+col regardless of MAX_KERNEL
    localparam int KSTRIDE    = 8;
    localparam int KMAX       = (MAX_KERNEL < KSTRIDE) ? MAX_KERNEL : KSTRIDE;
    localparam int MAX_HEIGHT = 1024;

    localparam int COEFF_BITS  = 16;
    localparam int CIDX_BITS   = 6;
    localparam int COEFF_DEPTH = 64;
    localparam int SUM_BITS    = 38;
    localparam int POS_BITS    = 10;
    localparam int DIM_BITS    = 11;
    localparam int KDIM_BITS   = 4;
    localparam int KIDX_BITS   = 3;
    localparam int PROD_BITS   = PIXEL_BITS + COEFF_BITS;

    localparam int LROW_BITS   = $clog2(MAX_KERNEL);
    localparam int LCOL_BITS   = $clog2(MAX_WIDTH);
    localparam int LINE_DEPTH  = MAX_KERNEL * MAX_WIDTH;
    localparam int LADDR_BITS  = LROW_BITS + LCOL_BITS;

    localparam int FIFO_DEPTH  = 2;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_KROWS  = 2'd2,
        REG_KCOLS  = 2'd3
    } reg_idx_t;

    typedef enum logic {
        REQ_COEFF = 1'b0,
        REQ_PIXEL = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } back_state_t;

    // effective (clamped) geometry
    typedef struct packed {
        logic [DIM_BITS-1:0]  width;
        logic [DIM_BITS-1:0]  height;
        logic [KDIM_BITS-1:0] krows;
        logic [KDIM_BITS-1:0] kcols;
    } geom_t;

    // one classified item, front to back
    typedef struct packed {
        req_t                         kind;
        logic [CIDX_BITS-1:0]         cidx;
        logic signed [COEFF_BITS-1:0] cval;
        logic signed [PIXEL_BITS-1:0] pix;
        logic [LADDR_BITS-1:0]        waddr;
        logic                         produce;
        logic [POS_BITS-1:0]          orow;
        logic [POS_BITS-1:0]          ocol;
        logic                         last;
    } cmd_t;

    function automatic logic [DIM_BITS-1:0] clamp_dim(logic [DIM_BITS-1:0] v,
                                                      logic [DIM_BITS-1:0] hi);
        logic [DIM_BITS-1:0] r;
        if (v == '0) r = DIM_BITS'(1);
        else if (v > hi) r = hi;
        else r = v;
        return r;
    endfunction

    function automatic logic [KDIM_BITS-1:0] clamp_k(logic [KDIM_BITS-1:0] v);
        logic [KDIM_BITS-1:0] r;
        if (v == '0) r = KDIM_BITS'(1);
        else if (v > KDIM_BITS'(KMAX)) r = KDIM_BITS'(KMAX);
        else r = v;
        return r;
    endfunction

endpackage

// ----- sv/v2c_ram.sv -----
module v2c_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/v2c_front.sv -----
module v2c_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  v2c_pkg::geom_t                     geom,
    input  logic                               in_fire,
    input  logic                               in_kind,
    input  logic [v2c_pkg::CIDX_BITS-1:0]      in_cidx,
    input  logic signed [v2c_pkg::COEFF_BITS-1:0] in_cval,
    input  logic signed [v2c_pkg::PIXEL_BITS-1:0] in_pix,
    output v2c_pkg::cmd_t                      cmd
);
    import v2c_pkg::*;

    logic [POS_BITS-1:0] row_reg, row_next;
    logic [POS_BITS-1:0] col_reg, col_next;
    logic [DIM_BITS-1:0] r1, c1, rn, cn;
    logic                rows_ok, cols_ok;
    logic [POS_BITS-1:0] orow, ocol;

    always_comb begin
        r1      = DIM_BITS'(row_reg) + DIM_BITS'(1);
        c1      = DIM_BITS'(col_reg) + DIM_BITS'(1);
        rows_ok = r1 >= DIM_BITS'(geom.krows);
        cols_ok = c1 >= DIM_BITS'(geom.kcols);
        orow    = POS_BITS'(r1 - DIM_BITS'(geom.krows));
        ocol    = POS_BITS'(c1 - DIM_BITS'(geom.kcols));

        cmd.kind    = req_t'(in_kind);
        cmd.cidx    = in_cidx;
        cmd.cval    = in_cval;
        cmd.pix     = in_pix;
        cmd.waddr   = {LROW_BITS'(row_reg), LCOL_BITS'(col_reg)};
        cmd.produce = rows_ok && cols_ok;
        cmd.orow    = orow;
        cmd.ocol    = ocol;
        cmd.last    = (geom.height >= DIM_BITS'(geom.krows))
                   && (geom.width >= DIM_BITS'(geom.kcols))
                   && (DIM_BITS'(orow) == geom.height - DIM_BITS'(geom.krows))
                   && (DIM_BITS'(ocol) == geom.width - DIM_BITS'(geom.kcols));

        // advance raster position; wrap on reaching or passing the limits
        rn = DIM_BITS'(row_reg);
        cn = c1;
        if (c1 >= geom.width) begin
            cn = '0;
            rn = r1;
            if (r1 >= geom.height) begin
                rn = '0;
            end
        end
        row_next = row_reg;
        col_next = col_reg;
        if (in_fire && in_kind == REQ_PIXEL) begin
            row_next = POS_BITS'(rn);
            col_next = POS_BITS'(cn);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

// ----- sv/v2c_fifo.sv -----
module v2c_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  v2c_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          nonempty,
    output v2c_pkg::cmd_t pop_data
);
    import v2c_pkg::*;

    localparam int PB = $clog2(FIFO_DEPTH);

    cmd_t          slot_reg [FIFO_DEPTH];
    logic [PB-1:0] wp_reg, wp_next;
    logic [PB-1:0] rp_reg, rp_next;
    logic [PB:0]   cnt_reg, cnt_next;

    always_comb begin
        full     = cnt_reg == (PB+1)'(FIFO_DEPTH);
        nonempty = cnt_reg != '0;
        pop_data = slot_reg[rp_reg];
        wp_next  = push ? ((wp_reg == PB'(FIFO_DEPTH-1)) ? '0 : wp_reg + PB'(1)) : wp_reg;
        rp_next  = pop ? ((rp_reg == PB'(FIFO_DEPTH-1)) ? '0 : rp_reg + PB'(1)) : rp_reg;
        cnt_next = cnt_reg + (PB+1)'(push) - (PB+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= push_data;
        end
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- sv/v2c_back.sv -----
module v2c_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  v2c_pkg::geom_t                      geom,
    input  logic                                q_nonempty,
    input  v2c_pkg::cmd_t                       q_data,
    output logic                                q_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [v2c_pkg::SUM_BITS-1:0] m_sum,
    output logic [v2c_pkg::POS_BITS-1:0]        m_row,
    output logic [v2c_pkg::POS_BITS-1:0]        m_col,
    output logic                                m_last
);
    import v2c_pkg::*;

    back_state_t state_reg, state_next;

    logic [KIDX_BITS-1:0] i_reg, j_reg;
    logic [POS_BITS-1:0]  orow_reg, ocol_reg;
    logic                 last_reg;

    logic                 line_we, coef_we, issue, issue_end, done;
    logic [LADDR_BITS-1:0] line_raddr;
    logic [CIDX_BITS-1:0]  coef_raddr;
    logic [PIXEL_BITS-1:0] line_rdata;
    logic [COEFF_BITS-1:0] coef_rdata;

    logic [COEFF_DEPTH-1:0] cvld_reg;
    logic                   cok_reg;
    logic                   rd_v_reg, rd_end_reg;
    logic                   mul_v_reg, mul_end_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [SUM_BITS-1:0]  acc_reg, acc_sum;
    logic signed [COEFF_BITS-1:0] coef_use;

    logic                        ov_reg;
    logic signed [SUM_BITS-1:0]  osum_reg;
    logic [POS_BITS-1:0]         orow_o_reg, ocol_o_reg;
    logic                        olast_o_reg;

    v2c_ram #(.WIDTH(PIXEL_BITS), .DEPTH(LINE_DEPTH)) u_line (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (q_data.waddr),
        .wdata (q_data.pix),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    v2c_ram #(.WIDTH(COEFF_BITS), .DEPTH(COEFF_DEPTH)) u_coef (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (q_data.cidx),
        .wdata (q_data.cval),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    always_comb begin
        issue_end  = (KDIM_BITS'(i_reg) == geom.krows - KDIM_BITS'(1))
                  && (KDIM_BITS'(j_reg) == geom.kcols - KDIM_BITS'(1));
        line_raddr = {LROW_BITS'(orow_reg + POS_BITS'(i_reg)),
                      LCOL_BITS'(ocol_reg + POS_BITS'(j_reg))};
        coef_raddr = {i_reg, j_reg};
        done       = mul_v_reg && mul_end_reg;
        coef_use   = cok_reg ? signed'(coef_rdata) : '0;
        acc_sum    = acc_reg + SUM_BITS'(prod_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_nonempty && !ov_reg && q_data.kind == REQ_PIXEL && q_data.produce) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        q_pop   = 1'b0;
        line_we = 1'b0;
        coef_we = 1'b0;
        issue   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                q_pop   = q_nonempty && !ov_reg;
                line_we = q_pop && q_data.kind == REQ_PIXEL;
                coef_we = q_pop && q_data.kind == REQ_COEFF;
            end
            ST_RUN: begin
                issue = 1'b1;
            end
            ST_DRAIN: begin
                issue = 1'b0;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        // window walk
        if (q_pop) begin
            i_reg    <= '0;
            j_reg    <= '0;
            orow_reg <= q_data.orow;
            ocol_reg <= q_data.ocol;
            last_reg <= q_data.last;
            acc_reg  <= '0;
        end else begin
            if (issue) begin
                if (KDIM_BITS'(j_reg) == geom.kcols - KDIM_BITS'(1)) begin
                    j_reg <= '0;
                    i_reg <= i_reg + KIDX_BITS'(1);
                end else begin
                    j_reg <= j_reg + KIDX_BITS'(1);
                end
            end
            if (mul_v_reg) begin
                acc_reg <= acc_sum;
            end
        end
        cok_reg     <= cvld_reg[coef_raddr];
        rd_end_reg  <= issue_end;
        mul_end_reg <= rd_end_reg;
        prod_reg    <= PROD_BITS'(signed'(line_rdata) * coef_use);
        if (done) begin
            osum_reg    <= acc_sum;
            orow_o_reg  <= orow_reg;
            ocol_o_reg  <= ocol_reg;
            olast_o_reg <= last_reg;
        end

        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cvld_reg  <= '0;
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (coef_we) begin
                cvld_reg[q_data.cidx] <= 1'b1;
            end
            rd_v_reg  <= issue;
            mul_v_reg <= rd_v_reg;
            if (done) begin
                ov_reg <= 1'b1;
            end else if (m_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign m_valid = ov_reg;
    assign m_sum   = osum_reg;
    assign m_row   = orow_o_reg;
    assign m_col   = ocol_o_reg;
    assign m_last  = olast_o_reg;

endmodule

// ----- sv/valid_2d_correlation.sv -----
// Streaming 2-D correlation, valid region only, no kernel flip.
// Input stream (s_*): one transfer per item. tuser = 0 writes a coefficient
// (index row*8+col in tdata), tuser = 1 delivers one pixel, image row-major.
// Result stream (m_*): one transfer per pixel that completes a window lying
// wholly inside the image; tdata carries the exact 38-bit sum and the output
// row and column, tlast flags the final result of the frame.
// APB port: image width, image height, kernel rows, kernel cols at byte
// addresses 0, 4, 8, 12; write only while the block is idle.
// Timing: a coefficient or a pixel that forms no window is taken by the back end
// while it stays idle. A pixel with a kr x kc window is walked in the run state
// and finished in the drain state; the MAC unit reads one line-store word and one
// coefficient a cycle through a single multiplier, reads and products registered.
// A 2-entry queue decouples input acceptance from the MAC engine, so input
// transfers continue while a result waits. When the receiver stalls, the
// finished result is held in the output register and the back end stops
// before starting the next item; the queue then fills and s_tready drops.
// Reset: counters, queue, coefficient store (reads as zero) and registers to
// 1024, 1024, 3, 3. The line store needs no clearing pass.
module valid_2d_correlation (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // coeff_index[5:0], coeff_value[21:6], pixel_value[37:22]
    input  logic [0:0]  s_tuser,   // req_type[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // sum_value[37:0], out_row[47:38], out_col[57:48]
    output logic        m_tlast    // frame_last
);
    import v2c_pkg::*;

    logic [DIM_BITS-1:0]  width_reg, height_reg;
    logic [KDIM_BITS-1:0] krows_reg, kcols_reg;
    reg_idx_t             ridx;
    logic                 cfg_wr;
    geom_t                geom;

    logic                 in_fire, q_full, q_nonempty, q_pop;
    cmd_t                 cmd_in, cmd_out;

    logic signed [SUM_BITS-1:0] r_sum;
    logic [POS_BITS-1:0]        r_row, r_col;

    // configuration registers
    assign pready = 1'b1;
    assign ridx   = reg_idx_t'(paddr[3:2]);
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (ridx)
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_KROWS:  prdata = 32'(krows_reg);
            REG_KCOLS:  prdata = 32'(kcols_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_BITS'(1024);
            height_reg <= DIM_BITS'(1024);
            krows_reg  <= KDIM_BITS'(3);
            kcols_reg  <= KDIM_BITS'(3);
        end else if (cfg_wr) begin
            case (ridx)
                REG_WIDTH:  width_reg  <= pwdata[DIM_BITS-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_BITS-1:0];
                REG_KROWS:  krows_reg  <= pwdata[KDIM_BITS-1:0];
                REG_KCOLS:  kcols_reg  <= pwdata[KDIM_BITS-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // zero acts as one, oversize saturates
    assign geom.width  = clamp_dim(width_reg, DIM_BITS'(MAX_WIDTH));
    assign geom.height = clamp_dim(height_reg, DIM_BITS'(MAX_HEIGHT));
    assign geom.krows  = clamp_k(krows_reg);
    assign geom.kcols  = clamp_k(kcols_reg);

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    v2c_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .geom    (geom),
        .in_fire (in_fire),
        .in_kind (s_tuser[0]),
        .in_cidx (s_tdata[5:0]),
        .in_cval (s_tdata[21:6]),
        .in_pix  (s_tdata[37:22]),
        .cmd     (cmd_in)
    );

    v2c_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .push_data (cmd_in),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .pop_data  (cmd_out)
    );

    v2c_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .geom       (geom),
        .q_nonempty (q_nonempty),
        .q_data     (cmd_out),
        .q_pop      (q_pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_sum      (r_sum),
        .m_row      (r_row),
        .m_col      (r_col),
        .m_last     (m_tlast)
    );

    assign m_tdata = {6'd0, r_col, r_row, r_sum};

endmodule

// ----- sim/valid_2d_correlation_tb.sv -----
`timescale 1ns/1ps

module valid_2d_correlation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import v2c_pkg::*;

    // No-transfer cycles before the run is declared hung. The slowest gap is an
    // 8x8 window behind a long receiver stall, or a drain pause.
    localparam int HANG_LIMIT = 5000;
    // Quiet cycles after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 80;
    // input transfers (pixels and coefficient writes) over the whole run
    localparam int ITEM_TARGET = 1600;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] total;
        logic [POS_BITS-1:0]        row;
        logic [POS_BITS-1:0]        col;
        logic                       last;
    } result_t;

    // one row of the directed table; a result is typed in where chk is set
    typedef struct {
        req_t                         kind;
        logic [CIDX_BITS-1:0]         idx;
        logic signed [COEFF_BITS-1:0] cval;
        logic signed [PIXEL_BITS-1:0] pix;
        bit                           chk;
        longint                       total;
    } vector_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;      // coeff_index[5:0], coeff_value[21:6], pixel_value[37:22]
    logic [0:0]  s_tuser;      // req_type[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;      // sum_value[37:0], out_row[47:38], out_col[57:48]
    logic        m_tlast;      // frame_last

    valid_2d_correlation DUT (.*);

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // ---------------------------------------------------------------------
    // Correlation predictor: own copy of registers, line store, coefficients
    // ---------------------------------------------------------------------
    logic [DIM_BITS-1:0]          cfg_width, cfg_height;
    logic [KDIM_BITS-1:0]         cfg_krows, cfg_kcols;
    logic signed [PIXEL_BITS-1:0] line_mem [MAX_KERNEL][MAX_WIDTH];
    logic signed [COEFF_BITS-1:0] coeff_mem [COEFF_DEPTH];
    int                           row_pos, col_pos;

    result_t pending_results[$];
    int      n_errors, n_pixels, n_coeffs, n_results, n_frames;

    // zero acts as one, oversize saturates
    function automatic int eff_size(int v, int hi);
        return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    task automatic correlate_item(req_t kind, logic [CIDX_BITS-1:0] idx,
                                  logic signed [COEFF_BITS-1:0] cval,
                                  logic signed [PIXEL_BITS-1:0] pix,
                                  output bit made, output result_t res);
        int     w, h, kr, kc, orow, ocol;
        longint acc;
        w    = eff_size(cfg_width, MAX_WIDTH);
        h    = eff_size(cfg_height, MAX_HEIGHT);
        kr   = eff_size(cfg_krows, KMAX);
        kc   = eff_size(cfg_kcols, KMAX);
        made = 1'b0;
        res  = '0;
        if (kind == REQ_COEFF) begin
            coeff_mem[idx] = cval;
            return;
        end
        line_mem[row_pos % MAX_KERNEL][col_pos % MAX_WIDTH] = pix;
        if (row_pos + 1 >= kr && col_pos + 1 >= kc) begin
            orow = row_pos + 1 - kr;
            ocol = col_pos + 1 - kc;
            acc  = 0;
            for (int i = 0; i < kr; i++)
                for (int j = 0; j < kc; j++)
                    acc += longint'(line_mem[(orow + i) % MAX_KERNEL][(ocol + j) % MAX_WIDTH])
                         * longint'(coeff_mem[i * KSTRIDE + j]);
            res.total = acc[SUM_BITS-1:0];
            res.row   = orow[POS_BITS-1:0];
            res.col   = ocol[POS_BITS-1:0];
            res.last  = (orow == h - kr) && (ocol == w - kc);
            made      = 1'b1;
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    // ---------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps.
    // Every routine returns just after a falling edge.
    // ---------------------------------------------------------------------
    int burst_left;

    task automatic send_item(req_t kind, logic [CIDX_BITS-1:0] idx,
                             logic signed [COEFF_BITS-1:0] cval,
                             logic signed [PIXEL_BITS-1:0] pix,
                             bit use_typed = 1'b0, result_t typed = '0);
        int      gap;
        bit      made;
        result_t res;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, pix, cval, idx};
        do @(posedge aclk); while (!s_tready);
        correlate_item(kind, idx, cval, pix, made, res);
        if (kind == REQ_PIXEL) n_pixels++;
        else n_coeffs++;
        if (use_typed) pending_results.push_back(typed);
        else if (made) pending_results.push_back(res);
        burst_left--;
        @(negedge aclk);
    endtask

    // hold off until every result is in, then let the back end settle
    task automatic drain_all();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_geometry(int w, int h, int kr, int kc);
        drain_all();
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
        apb_write(REG_KROWS, kr);
        apb_write(REG_KCOLS, kc);
        cfg_width  = w[DIM_BITS-1:0];
        cfg_height = h[DIM_BITS-1:0];
        cfg_krows  = kr[KDIM_BITS-1:0];
        cfg_kcols  = kc[KDIM_BITS-1:0];
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(signed'($urandom_range(0, 2)) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    // one whole frame; unless the pixel value is fixed, occasional coefficient writes slip in mid-frame
    task automatic send_frame(int fixed_mode, logic signed [15:0] fixed_pix);
        int n;
        n = eff_size(cfg_width, MAX_WIDTH) * eff_size(cfg_height, MAX_HEIGHT);
        for (int p = 0; p < n; p++) begin
            if (fixed_mode == 0 && $urandom_range(0, 15) == 0)
                send_item(REQ_COEFF, 6'($urandom), pick_sample(), 16'($urandom));
            send_item(REQ_PIXEL, 6'($urandom), 16'($urandom),
                      fixed_mode ? fixed_pix : pick_sample());
        end
        n_frames++;
    endtask

    task automatic load_kernel(bit all, bit fixed, logic signed [15:0] value);
        int n;
        n = all ? COEFF_DEPTH : $urandom_range(0, 20);
        for (int k = 0; k < n; k++)
            send_item(REQ_COEFF, all ? 6'(k) : 6'($urandom),
                      fixed ? value : pick_sample(), 16'($urandom));
    endtask

    // ---------------------------------------------------------------------
    // Receiver: stall density switches among four levels over the run, including none
    // ---------------------------------------------------------------------
    int stall_pct = 0;
    int rx_cycle = 0;

    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 256 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 25;
                2: stall_pct <= 60;
                default: stall_pct <= 90;
            endcase
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ---------------------------------------------------------------------
    // Result checker: each result transfer against the oldest expectation
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer sum %0d row %0d col %0d",
                         $realtime, $signed(m_tdata[37:0]), m_tdata[47:38], m_tdata[57:48]);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                n_results++;
                if (m_tdata[37:0] !== want.total) begin
                    $display("%0t: sum mismatch, expected %0d actual %0d", $realtime,
                             want.total, $signed(m_tdata[37:0]));
                    n_errors++;
                end
                if (m_tdata[47:38] !== want.row) begin
                    $display("%0t: row mismatch, expected %0d actual %0d", $realtime,
                             want.row, m_tdata[47:38]);
                    n_errors++;
                end
                if (m_tdata[57:48] !== want.col) begin
                    $display("%0t: col mismatch, expected %0d actual %0d", $realtime,
                             want.col, m_tdata[57:48]);
                    n_errors++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: tlast mismatch, expected %0b actual %0b", $realtime,
                             want.last, m_tlast);
                    n_errors++;
                end
            end
        end
    end

    // watchdog: ends the run when no transfer of any kind happens for too long
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("%0t: hang, %0d results outstanding", $realtime,
                     pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Directed table, run on a 1x1 image with a 1x1 kernel (all registers
    // zero, which act as one), so every result is a single product.
    // ---------------------------------------------------------------------
    vector_t directed [14] = '{
        '{REQ_PIXEL, 6'd0,  16'sd0,      16'sd12345,  1, 0},   // coefficients zeroed by the earlier writes
        '{REQ_COEFF, 6'd0,  -16'sd32768, 16'sd0,      0, 0},
        '{REQ_PIXEL, 6'd0,  16'sd0,      -16'sd32768, 1, 64'sd1073741824},
        '{REQ_PIXEL, 6'd0,  16'sd0,      16'sd32767,  1, -64'sd1073709056},
        '{REQ_COEFF, 6'd0,  16'sd32767,  16'sd0,      0, 0},
        '{REQ_PIXEL, 6'd0,  16'sd0,      -16'sd32768, 1, -64'sd1073709056},
        '{REQ_PIXEL, 6'd0,  16'sd0,      16'sd32767,  1, 64'sd1073676289},
        '{REQ_COEFF, 6'd63, 16'sd32767,  16'sd0,      0, 0},   // unused position
        '{REQ_COEFF, 6'd42, -16'sd1,     16'sd0,      0, 0},
        '{REQ_PIXEL, 6'd0,  16'sd0,      16'sd0,      1, 0},
        '{REQ_COEFF, 6'd0,  16'sd1,      16'sd0,      0, 0},
        '{REQ_PIXEL, 6'd21, 16'sd0,      -16'sd1,     1, -64'sd1},
        '{REQ_PIXEL, 6'd0,  16'sd0,      16'sd21845,  1, 64'sd21845},
        '{REQ_PIXEL, 6'd0,  16'sd0,      -16'sd21846, 1, -64'sd21846}
    };

    initial begin
        result_t typed;
        int      w, h, kr, kc;

        aresetn   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        n_errors  = 0;
        n_pixels  = 0;
        n_coeffs  = 0;
        n_results = 0;
        n_frames  = 0;
        burst_left = 0;
        row_pos   = 0;
        col_pos   = 0;
        cfg_width = 11'd1024;
        cfg_height = 11'd1024;
        cfg_krows = 4'd3;
        cfg_kcols = 4'd3;
        foreach (coeff_mem[k]) coeff_mem[k] = '0;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // coefficient writes only under the reset geometry (no frame started)
        load_kernel(1'b0, 1'b0, 16'sd0);
        foreach (coeff_mem[k]) coeff_mem[k] = '0;
        for (int k = 0; k < COEFF_DEPTH; k++)
            send_item(REQ_COEFF, 6'(k), 16'sd0, 16'sd0);

        set_geometry(0, 0, 0, 0);
        foreach (directed[v]) begin
            typed       = '0;
            typed.total = directed[v].total[SUM_BITS-1:0];
            typed.last  = 1'b1;
            send_item(directed[v].kind, directed[v].idx, directed[v].cval,
                      directed[v].pix, directed[v].chk, typed);
        end

        // extreme geometries: saturating width and kernel, tall thin image,
        // kernel bigger than the image, and the largest possible sums
        set_geometry(2047, 1, 1, 15);
        load_kernel(1'b1, 1'b0, 16'sd0);
        send_frame(0, 16'sd0);
        set_geometry(1, 24, 15, 1);
        load_kernel(1'b1, 1'b0, 16'sd0);
        send_frame(0, 16'sd0);
        set_geometry(3, 2, 4, 2);
        send_frame(0, 16'sd0);
        set_geometry(8, 8, 8, 8);
        load_kernel(1'b1, 1'b1, -16'sd32768);
        send_frame(1, -16'sd32768);
        send_frame(1, 16'sd32767);

        // random frames, small images
        while (n_pixels + n_coeffs < ITEM_TARGET) begin
            w = $urandom_range(0, 12);
            h = $urandom_range(0, 12);
            kr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            kc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            set_geometry(w, h, kr, kc);
            load_kernel($urandom_range(0, 3) == 0, 1'b0, 16'sd0);
            repeat ($urandom_range(1, 3)) begin
                send_frame(0, 16'sd0);
                // sender waits for every outstanding result now and then
                if ($urandom_range(0, 3) == 0) drain_all();
            end
        end

        drain_all();
        $display("Covered %0d pixels and %0d coefficient writes over %0d frames;",
                 n_pixels, n_coeffs, n_frames);
        $display("%0d window sums checked, %0d mismatches.", n_results, n_errors);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- valid_2d_correlation.f -----
sv/v2c_pkg.sv
sv/v2c_ram.sv
sv/v2c_front.sv
sv/v2c_fifo.sv
sv/v2c_back.sv
sv/valid_2d_correlation.sv
sim/valid_2d_correlation_tb.sv
